[design/sitoa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;

  // magnitude bits folded into the BCD register per conversion cycle
  localparam int BitsPerCycle = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

endpackage : sitoa_pkg
`default_nettype wire

[design/signed_int_to_decimal_ascii_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts two's complement integers to decimal ASCII text, one character
// per output word, most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
// Each input word is queued (two entries) with its sign and magnitude, then
// converted by a shift-add-3 BCD unit that folds four magnitude bits per
// cycle. The digit stage then drops one leading zero per cycle and sends one
// character per cycle, while the output is not stalled, through an output
// register. The BCD register holds 10 digits at 32 bits, and a negative
// value gets a minus character ahead of its digits. The input side keeps
// accepting while the queue has room.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core import sitoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic        [7:0]                 out_character,
  output logic                              out_last
);

  logic                  q_valid;
  logic                  q_pop;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;

  sitoa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_neg    (q_neg),
    .q_mag    (q_mag)
  );

  sitoa_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_neg         (q_neg),
    .q_mag         (q_mag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule : signed_int_to_decimal_ascii_core
`default_nettype wire

[design/sitoa_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_front
// Accepts input words, splits off the sign and forms the unsigned magnitude,
// and holds them in a two-entry queue for the conversion back end.
// ----------------------------------------------------------------------------
module sitoa_front import sitoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              q_valid,
  input  wire logic                         q_pop,
  output logic                              q_neg,
  output logic        [VALUE_BITS-1:0]      q_mag
);

  logic [VALUE_BITS-1:0] v_u;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;

  logic                  neg_mem [2];
  logic [VALUE_BITS-1:0] mag_mem [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            count_r, count_nxt;

  assign v_u  = VALUE_BITS'(in_value);
  assign neg  = v_u[VALUE_BITS-1];
  assign mag  = neg ? (~v_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_u;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_neg    = neg_mem[rd_ptr_r];
  assign q_mag    = mag_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !(q_pop && q_valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      neg_mem[wr_ptr_r] <= neg;
      mag_mem[wr_ptr_r] <= mag;
    end
  end

endmodule : sitoa_front
`default_nettype wire

[design/sitoa_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_back
// Shift-add-3 binary to BCD converter, four magnitude bits per cycle, then
// emits the sign and digits most significant first, skipping leading zeros.
// ----------------------------------------------------------------------------
module sitoa_back import sitoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  output logic                         q_pop,
  input  wire logic                    q_neg,
  input  wire logic [VALUE_BITS-1:0]   q_mag,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  localparam int NumDigits = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int ConvSteps = (VALUE_BITS + BitsPerCycle - 1) / BitsPerCycle;
  localparam int PadBits   = ConvSteps * BitsPerCycle;
  localparam int BcdBits   = NumDigits * 4;
  localparam int CntW      = $clog2(ConvSteps + 1);
  localparam int LeftW     = $clog2(NumDigits + 1);

  back_state_t           state_r, state_nxt;
  logic [PadBits-1:0]    mag_r, mag_nxt;
  logic [BcdBits-1:0]    bcd_r, bcd_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [LeftW-1:0]      left_r, left_nxt;
  logic                  neg_r, neg_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ob_free;
  logic [BcdBits-1:0]    bcd_dab;
  logic [3:0]            top_digit;
  logic                  skip_zero;
  logic                  last_digit;

  assign ob_free    = !out_valid_r || !out_stall;
  assign top_digit  = bcd_r[BcdBits-1 -: 4];
  assign last_digit = (left_r == LeftW'(1));
  assign skip_zero  = !started_r && !last_digit && (top_digit == 4'd0);

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  always_comb begin
    logic [BcdBits-1:0] b;
    logic [3:0]         d;
    b = bcd_r;
    for (int j = 0; j < BitsPerCycle; j++) begin
      for (int k = 0; k < NumDigits; k++) begin
        d = b[k*4 +: 4];
        if (d >= 4'd5) begin
          b[k*4 +: 4] = d + 4'd3;
        end
      end
      b = {b[BcdBits-2:0], mag_r[PadBits-1-j]};
    end
    bcd_dab = b;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_r == CntW'(1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (ob_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!skip_zero && ob_free && last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          mag_nxt     = PadBits'(q_mag);
          bcd_nxt     = '0;
          cnt_nxt     = CntW'(ConvSteps);
          neg_nxt     = q_neg;
          started_nxt = 1'b0;
        end
      end
      ST_CONV: begin
        bcd_nxt  = bcd_dab;
        mag_nxt  = mag_r << BitsPerCycle;
        cnt_nxt  = cnt_r - CntW'(1);
        left_nxt = LeftW'(NumDigits);
      end
      ST_SIGN: begin
        if (ob_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      ST_EMIT: begin
        if (skip_zero) begin
          bcd_nxt  = bcd_r << 4;
          left_nxt = left_r - LeftW'(1);
        end else if (ob_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO | {4'd0, top_digit};
          out_last_nxt  = last_digit;
          bcd_nxt       = bcd_r << 4;
          left_nxt      = left_r - LeftW'(1);
          started_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    left_r     <= left_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule : sitoa_back
`default_nettype wire

[bench/sitoa_checker.sv]
// ----------------------------------------------------------------------------
// sitoa_checker
// Watches both channels of the integer to decimal ASCII core. Every accepted
// integer is turned into its expected character words, and each accepted
// output word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module sitoa_checker import sitoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic        [7:0]            out_character,
  input  logic                         out_last,
  output int                           errors,
  output int                           pending,
  output int                           words_in,
  output int                           words_out,
  output int                           negatives
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } glyph_t;

  glyph_t text_q[$];

  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [7:0]            digs[24];
    int                    nd;
    glyph_t                g;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = ASCII_ZERO + 8'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (v[VALUE_BITS-1]) begin
      g.ch = ASCII_MINUS;
      g.last = 1'b0;
      text_q.push_back(g);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      g.ch = digs[k];
      g.last = (k == 0);
      text_q.push_back(g);
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        queue_decimal_text(in_value);
        words_in++;
        if (in_value[VALUE_BITS-1]) negatives++;
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (text_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word: char %0d last %0b", $realtime,
                     out_character, out_last);
        end else begin
          want = text_q.pop_front();
          if (want.ch !== out_character || want.last !== out_last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: word mismatch: expected char %0d last %0b, got char %0d last %0b",
                       $realtime, want.ch, want.last, out_character, out_last);
          end
        end
      end
      pending = text_q.size();
    end
  end

endmodule : sitoa_checker

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the integer to decimal ASCII core with corner integers and then
// random ones of mixed lengths and signs, with random gaps on the input side
// and random stalls on the output side. Checking is done by sitoa_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 32;
  localparam int RANDOM_WORDS = 210;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VB-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic        [7:0]    out_character;
  logic                 out_last;

  int  errors, pending, words_in, words_out, negatives;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  out_taken = 1'b0;
  int  rx_wait = 0;

  int corner[] = '{0, 1, -1, 9, 10, -10, 99, -100, 7, -9, 123456789, -987654321,
                   999999999, 1000000000, -999999999, -1000000000, 2147483647,
                   32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
                   1999999999};

  signed_int_to_decimal_ascii_core #(.VALUE_BITS(VB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  sitoa_checker #(.VALUE_BITS(VB)) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last),
    .errors       (errors),
    .pending      (pending),
    .words_in     (words_in),
    .words_out    (words_out),
    .negatives    (negatives)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: draws a stall length after every accepted word
  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_taken) rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_value(input int v);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int draw_value();
    int     kind;
    int     v;
    longint p;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      v = $urandom;
    end else if (kind < 6) begin
      v = $urandom >> $urandom_range(1, 31);
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind < 8) begin
      v = $urandom_range(0, 40) - 20;
    end else begin
      p = 1;
      repeat ($urandom_range(0, 9)) p = p * 10;
      p = p + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) p = -p;
      v = int'(p);
    end
    return v;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (corner[i]) push_value(corner[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_burst = ((i / 30) % 4 == 1) || ((i / 30) % 4 == 3);
      rx_burst = ((i / 30) % 4 >= 2);
      push_value(draw_value());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Converted %0d integers (%0d negative) into %0d characters.",
             words_in, negatives, words_out);
    $display("Input gaps and output stalls of 0 to 10 cycles, with burst stretches.");
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule : tb_top
